@@ src/swm_pkg.sv @@
// Package for the sliding window maximum block: widths, register map and the
// control bundle that drives the candidate cell chain. No dependencies.
package swm_pkg;

    localparam int WINDOW_MAX_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 32;

    // Candidate ages and the window size register share one width.
    localparam int AGE_W  = 7;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Register map: word index taken from paddr[2].
    localparam logic REG_WINDOW_SIZE = 1'b0;

    localparam logic [AGE_W-1:0] WINDOW_RESET = AGE_W'(1);

    // Per-cycle command to every cell of the chain.
    typedef struct packed {
        logic             purge;  // drop the front candidate, no ageing
        logic             step;   // a sample transaction is taken this cycle
        logic             shift;  // front candidate leaves the window on this step
        logic             flush;  // end of stream: empty the chain
        logic [AGE_W-1:0] k;      // effective window length
    } t_cell_ctl;

endpackage

@@ src/swm_cell.sv @@
// One candidate slot of the monotonic queue: value, age and occupancy.
// Depends on swm_pkg; instantiated in a row by sliding_window_maximum_top.
module swm_cell #(
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  swm_pkg::t_cell_ctl           i_ctl,
    input  logic [SAMPLE_WIDTH-1:0]      i_sample,
    input  logic                         i_left_keep,
    input  logic                         i_right_valid,
    input  logic [SAMPLE_WIDTH-1:0]      i_right_value,
    input  logic [swm_pkg::AGE_W-1:0]    i_right_age,
    output logic                         o_valid,
    output logic [SAMPLE_WIDTH-1:0]      o_value,
    output logic [swm_pkg::AGE_W-1:0]    o_age,
    output logic                         o_keep,
    output logic                         o_expired
);

    logic                      r_valid, n_valid;
    logic [SAMPLE_WIDTH-1:0]   r_value, n_value;
    logic [swm_pkg::AGE_W-1:0] r_age, n_age;

    logic                      w_src_valid;
    logic [SAMPLE_WIDTH-1:0]   w_src_value;
    logic [swm_pkg::AGE_W-1:0] w_src_age;
    logic [swm_pkg::AGE_W-1:0] w_src_aged;
    logic [swm_pkg::AGE_W-1:0] w_own_aged;
    logic                      w_keep;

    // Ages saturate at all ones.
    assign w_own_aged = (r_age == '1) ? r_age : r_age + 1'b1;
    assign o_expired  = r_valid && (w_own_aged >= i_ctl.k);

    always_comb begin
        if (i_ctl.shift) begin
            w_src_valid = i_right_valid;
            w_src_value = i_right_value;
            w_src_age   = i_right_age;
        end else begin
            w_src_valid = r_valid;
            w_src_value = r_value;
            w_src_age   = r_age;
        end
    end

    assign w_src_aged = (w_src_age == '1) ? w_src_age : w_src_age + 1'b1;
    // Survives only if strictly larger than the incoming sample.
    assign w_keep     = w_src_valid && ($signed(w_src_value) > $signed(i_sample));

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        n_age   = r_age;
        if (i_ctl.purge) begin
            n_valid = i_right_valid;
            n_value = i_right_value;
            n_age   = i_right_age;
        end else if (i_ctl.step) begin
            if (i_ctl.flush) begin
                n_valid = 1'b0;
            end else if (w_keep) begin
                n_valid = 1'b1;
                n_value = w_src_value;
                n_age   = w_src_aged;
            end else begin
                // First free slot behind the survivors takes the sample.
                n_valid = i_left_keep;
                n_value = i_sample;
                n_age   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_age   <= '0;
        end else begin
            r_valid <= n_valid;
            r_age   <= n_age;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_age   = r_age;
    assign o_keep  = w_keep;

endmodule

@@ src/swm_cfg.sv @@
// APB register slave holding the window size, with range clamping.
// Depends on swm_pkg.
module swm_cfg #(
    parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [swm_pkg::APB_AW-1:0]   paddr,
    input  logic [swm_pkg::APB_DW-1:0]   pwdata,
    output logic [swm_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output logic [swm_pkg::AGE_W-1:0]    o_k
);

    logic [swm_pkg::AGE_W-1:0] r_window_size, n_window_size;
    logic                      w_wr_en;

    assign pready  = 1'b1;
    assign w_wr_en = psel && penable && pwrite && pready
                     && (paddr[2] == swm_pkg::REG_WINDOW_SIZE);

    always_comb begin
        n_window_size = r_window_size;
        if (w_wr_en) begin
            n_window_size = pwdata[swm_pkg::AGE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= swm_pkg::WINDOW_RESET;
        end else begin
            r_window_size <= n_window_size;
        end
    end

    always_comb begin
        unique case (paddr[2])
            swm_pkg::REG_WINDOW_SIZE: prdata = swm_pkg::APB_DW'(r_window_size);
            default:                  prdata = '0;
        endcase
    end

    // Zero acts as one, anything above the chain length as the chain length.
    always_comb begin
        if (r_window_size == '0) begin
            o_k = swm_pkg::AGE_W'(1);
        end else if (32'(r_window_size) > 32'(WINDOW_MAX)) begin
            o_k = swm_pkg::AGE_W'(WINDOW_MAX);
        end else begin
            o_k = r_window_size;
        end
    end

endmodule

@@ src/sliding_window_maximum_top.sv @@
// Sliding window maximum: top level with stream ports, APB register port and
// the candidate cell chain. Depends on swm_pkg, swm_cell and swm_cfg.
//
// Usage notes
// - Sample transactions enter on s_axis: tdata carries the signed sample in
//   its low SAMPLE_WIDTH bits, tlast marks the final sample of a stream.
// - Result transactions leave on m_axis: tdata carries the window maximum,
//   tlast marks the result of the stream's final sample.
// - From the window_size-th sample of a stream on, every sample yields a
//   result; the final sample always yields one, after which the chain empties.
// - Throughput: one sample per cycle while m_axis takes the results. After
//   window_size is lowered in the middle of a stream, each candidate beyond
//   the first that has fallen out of the window is shifted out of the chain
//   before the next sample is taken.
// - Latency: the result is registered, valid the cycle after acceptance.
// - A stalled m_axis holds its result; s_axis_tready drops until the output
//   register has been taken, so nothing is lost.
// - Reset (synchronous, active low) empties the chain by its valid bits and
//   sets window_size to 1; no clearing pass.
// - window_size sits at byte address 0 of the APB port; write it only when
//   no result is outstanding.
module sliding_window_maximum_top #(
    parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // s_axis_tdata: [SAMPLE_WIDTH-1:0] sample, upper bits zero
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    input  logic                                 s_axis_tlast,
    // m_axis_tdata: [SAMPLE_WIDTH-1:0] window_max, upper bits zero
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
    output logic                                 m_axis_tlast,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [swm_pkg::APB_AW-1:0]           paddr,
    input  logic [swm_pkg::APB_DW-1:0]           pwdata,
    output logic [swm_pkg::APB_DW-1:0]           prdata,
    output logic                                 pready
);

    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int AGE_W   = swm_pkg::AGE_W;

    logic [AGE_W-1:0]        w_k;
    swm_pkg::t_cell_ctl      w_ctl;
    logic [SAMPLE_WIDTH-1:0] w_sample;

    // Chain wiring; the extra slot at the end reads as an empty neighbour.
    logic                    w_valid   [0:WINDOW_MAX];
    logic [SAMPLE_WIDTH-1:0] w_value   [0:WINDOW_MAX];
    logic [AGE_W-1:0]        w_age     [0:WINDOW_MAX];
    logic                    w_expired [0:WINDOW_MAX];
    logic                    w_keep    [0:WINDOW_MAX];

    logic                    w_out_free;
    logic                    w_purge_needed;
    logic                    w_take;
    logic [SAMPLE_WIDTH-1:0] w_head_src;
    logic [SAMPLE_WIDTH-1:0] w_head_next;
    logic [AGE_W-1:0]        w_seen_inc;
    logic                    w_emit;

    logic                    r_out_valid, n_out_valid;
    logic [SAMPLE_WIDTH-1:0] r_out_value, n_out_value;
    logic                    r_out_last,  n_out_last;
    logic [AGE_W-1:0]        r_seen,      n_seen;

    swm_cfg #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_k     (w_k)
    );

    assign w_sample = s_axis_tdata[SAMPLE_WIDTH-1:0];

    // Normally only the front candidate can leave per sample. More than one
    // expired (window shrunk) means shift the front out first, one a cycle while a sample is offered.
    assign w_purge_needed = w_expired[0] && w_expired[1];
    assign w_out_free     = !r_out_valid || m_axis_tready;
    assign s_axis_tready  = !w_purge_needed && w_out_free;
    assign w_take         = s_axis_tvalid && s_axis_tready;

    always_comb begin
        w_ctl.purge = s_axis_tvalid && w_purge_needed;
        w_ctl.step  = w_take;
        w_ctl.shift = w_expired[0];
        w_ctl.flush = s_axis_tlast;
        w_ctl.k     = w_k;
    end

    assign w_valid[WINDOW_MAX]   = 1'b0;
    assign w_value[WINDOW_MAX]   = '0;
    assign w_age[WINDOW_MAX]     = '0;
    assign w_expired[WINDOW_MAX] = 1'b0;
    assign w_keep[WINDOW_MAX]    = 1'b0;

    for (genvar gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
        logic w_left_keep;
        if (gi == 0) begin : g_head
            assign w_left_keep = 1'b1;
        end else begin : g_body
            assign w_left_keep = w_keep[gi-1];
        end

        swm_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_sample      (w_sample),
            .i_left_keep   (w_left_keep),
            .i_right_valid (w_valid[gi+1]),
            .i_right_value (w_value[gi+1]),
            .i_right_age   (w_age[gi+1]),
            .o_valid       (w_valid[gi]),
            .o_value       (w_value[gi]),
            .o_age         (w_age[gi]),
            .o_keep        (w_keep[gi]),
            .o_expired     (w_expired[gi])
        );
    end

    // Front of the queue after this sample: the surviving head or the sample.
    assign w_head_src  = w_expired[0] ? w_value[1] : w_value[0];
    assign w_head_next = w_keep[0] ? w_head_src : w_sample;

    assign w_seen_inc = (r_seen == '1) ? r_seen : r_seen + 1'b1;
    assign w_emit     = (w_seen_inc >= w_k) || s_axis_tlast;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        n_seen      = r_seen;
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        if (w_take) begin
            n_seen = s_axis_tlast ? '0 : w_seen_inc;
            if (w_emit) begin
                n_out_valid = 1'b1;
                n_out_value = w_head_next;
                n_out_last  = s_axis_tlast;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_seen      <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_seen      <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'(r_out_value);
    assign m_axis_tlast  = r_out_last;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for sliding_window_maximum_top: queues sample
// transactions, programs window_size over APB and checks every window maximum.
// Depends on swm_pkg and the RTL of the block.
module testbench;

    localparam int SW = swm_pkg::SAMPLE_WIDTH_DEF;
    localparam int WMAX = swm_pkg::WINDOW_MAX_DEF;
    localparam int AGE_W = swm_pkg::AGE_W;
    localparam int APB_AW = swm_pkg::APB_AW;
    localparam int APB_DW = swm_pkg::APB_DW;
    localparam int DW = ((SW + 7) / 8) * 8;
    localparam logic [APB_AW-1:0] ADDR_WINDOW =
        APB_AW'(4 * int'(swm_pkg::REG_WINDOW_SIZE));
    localparam logic [AGE_W-1:0] AGE_CAP = '1;
    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1030;
    localparam int HOLD_AFTER = 400;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic signed [SW-1:0] data;
        logic                 eos;
    } t_sample;

    typedef struct packed {
        logic signed [SW-1:0] value;
        logic                 last;
    } t_max;

    typedef enum {VALUES_WIDE, VALUES_NARROW, VALUES_EDGE, VALUES_FALLING} t_value_mix;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    // s_axis_tdata: [SW-1:0] sample
    logic [DW-1:0]     s_axis_tdata = '0;
    logic              s_axis_tlast = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // m_axis_tdata: [SW-1:0] window_max
    logic [DW-1:0]     m_axis_tdata;
    logic              m_axis_tlast;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // Predictor state: candidate queue, oldest first, strictly falling values
    logic signed [SW-1:0] cand_value [WMAX];
    logic [AGE_W-1:0]     cand_age [WMAX];
    int                   cand_count = 0;
    logic [AGE_W-1:0]     stream_seen = '0;
    logic [AGE_W-1:0]     window_reg = swm_pkg::WINDOW_RESET;

    t_sample sample_queue [$];
    t_max    expected_maxima [$];

    int      cycle_count = 0;
    int      mismatch_count = 0;
    int      items_taken = 0;
    int      tx_idle = 0;
    int      rx_idle = 0;
    int      rx_hold = 0;
    int      rx_draw;
    bit      long_hold_done = 1'b0;
    bit      tx_burst = 1'b0;
    bit      rx_burst = 1'b0;
    t_sample offered;
    t_sample next_sample;
    t_max    want_max;

    sliding_window_maximum_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    task automatic flag_mismatch(input string what);
        $display("mismatch, cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // In a burst every transaction goes back to back; otherwise half do and the rest draw a random idle wait.
    function automatic int draw_idle(input bit burst);
        if (burst || $urandom_range(0, 1) == 0) begin
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    // Ages the candidates, drops stale and outranked ones, enters the new
    // sample and queues the window maximum if this sample yields one.
    function automatic void track_window_max(input t_sample smp);
        logic [AGE_W-1:0]     span;
        logic [AGE_W-1:0]     age;
        logic signed [SW-1:0] v;
        int                   kept;
        int                   i;
        t_max                 res;
        span = window_reg;
        if (span == '0) begin
            span = AGE_W'(1);
        end
        if (span > AGE_W'(WMAX)) begin
            span = AGE_W'(WMAX);
        end
        v = smp.data;
        kept = 0;
        for (i = 0; i < cand_count; i++) begin
            age = cand_age[i];
            if (age != AGE_CAP) begin
                age = age + 1'b1;
            end
            if (age < span) begin
                cand_value[kept] = cand_value[i];
                cand_age[kept] = age;
                kept++;
            end
        end
        cand_count = kept;
        // equal values give way too, so the newest copy survives
        while (cand_count > 0 && v >= cand_value[cand_count - 1]) begin
            cand_count--;
        end
        if (cand_count < WMAX) begin
            cand_value[cand_count] = v;
            cand_age[cand_count] = '0;
            cand_count++;
        end
        if (stream_seen != AGE_CAP) begin
            stream_seen = stream_seen + 1'b1;
        end
        if (stream_seen >= span || smp.eos) begin
            res.value = cand_value[0];
            res.last = smp.eos;
            expected_maxima = {expected_maxima, res};
            if (smp.eos) begin
                cand_count = 0;
                stream_seen = '0;
            end
        end
    endfunction

    // Sample driver: fed from sample_queue, predicts on every accepted transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_idle <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                offered.data = s_axis_tdata[SW-1:0];
                offered.eos = s_axis_tlast;
                track_window_max(offered);
                items_taken <= items_taken + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_idle > 0) begin
                    tx_idle <= tx_idle - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (sample_queue.size() > 0) begin
                    next_sample = sample_queue[0];
                    sample_queue.delete(0);
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= DW'($unsigned(next_sample.data));
                    s_axis_tlast <= next_sample.eos;
                    tx_idle <= draw_idle(tx_burst);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // One long hold-off of the receiver, counted here, that lets the output
    // register fill and stall the input side.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_hold <= 0;
            long_hold_done <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
        end else if (!long_hold_done && items_taken >= HOLD_AFTER) begin
            long_hold_done <= 1'b1;
            rx_hold <= HOLD_CYCLES;
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_idle <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_maxima.size() == 0) begin
                    flag_mismatch($sformatf("result %0d with nothing outstanding",
                                            $signed(m_axis_tdata[SW-1:0])));
                end else begin
                    want_max = expected_maxima[0];
                    expected_maxima.delete(0);
                    if (m_axis_tdata[SW-1:0] !== want_max.value) begin
                        flag_mismatch($sformatf("window_max %0d, wanted %0d",
                                                $signed(m_axis_tdata[SW-1:0]),
                                                want_max.value));
                    end
                    if (m_axis_tlast !== want_max.last) begin
                        flag_mismatch($sformatf("last_result %b, wanted %b",
                                                m_axis_tlast, want_max.last));
                    end
                end
            end
            if (rx_hold > 0) begin
                m_axis_tready <= 1'b0;
            end else if (m_axis_tvalid && m_axis_tready) begin
                rx_draw = draw_idle(rx_burst);
                if (rx_draw == 0) begin
                    m_axis_tready <= 1'b1;
                end else begin
                    m_axis_tready <= 1'b0;
                    rx_idle <= rx_draw - 1;
                end
            end else if (rx_idle > 0) begin
                rx_idle <= rx_idle - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic add_sample(input logic signed [SW-1:0] v, input logic eos);
        t_sample smp;
        smp.data = v;
        smp.eos = eos;
        sample_queue = {sample_queue, smp};
    endtask

    // Waits until every queued sample is taken and every result checked,
    // sampled on the falling edge, then lets the block settle.
    task automatic wait_quiet();
        do @(negedge i_clk);
        while (sample_queue.size() != 0 || s_axis_tvalid || expected_maxima.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // APB write of window_size, sometimes with junk above the register bits.
    task automatic program_window(input logic [AGE_W-1:0] w);
        logic [APB_DW-1:0] junk;
        junk = ($urandom_range(0, 1) == 1) ? APB_DW'($urandom) : '0;
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_WINDOW;
        pwdata <= {junk[APB_DW-1:AGE_W], w};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        window_reg = w;
    endtask

    localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

    initial begin
        int                   j;
        int                   r;
        int                   phase;
        int                   phase_len;
        int                   random_items;
        int                   stream_left;
        logic [AGE_W-1:0]     w;
        logic [AGE_W-1:0]     span;
        t_value_mix           mix;
        logic signed [SW-1:0] v;
        logic signed [SW-1:0] ramp_level;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset window of one: every sample is its own maximum, extremes first
        add_sample(S_MAX, 1'b0);
        add_sample(S_MIN, 1'b0);
        add_sample('0, 1'b0);
        add_sample('1, 1'b1);
        wait_quiet();

        // Window of four: equal samples, a short stream, a falling run
        program_window(AGE_W'(4));
        for (j = 0; j < 5; j++) begin
            add_sample(SW'(5), j == 4);
        end
        add_sample(-SW'(7), 1'b0);
        add_sample(S_MIN, 1'b1);
        for (j = 0; j < 6; j++) begin
            add_sample(SW'(10 - j), j == 5);
        end
        wait_quiet();

        // Full window, then lowered mid-stream so stale candidates must go
        program_window(AGE_W'(WMAX));
        for (j = 0; j < 6; j++) begin
            add_sample(SW'(100 - 10 * j), 1'b0);
        end
        wait_quiet();
        program_window(AGE_W'(2));
        add_sample(SW'(40), 1'b0);
        add_sample(SW'(45), 1'b1);
        wait_quiet();

        // Random phases; streams run on across window changes
        random_items = 0;
        phase = 0;
        stream_left = 0;
        ramp_level = S_MAX;
        while (random_items < RANDOM_ITEMS) begin
            case (phase)
                0: w = '0;
                1: w = AGE_CAP;
                2: w = AGE_W'(WMAX);
                3: w = AGE_W'(1);
                default: begin
                    r = $urandom_range(0, 7);
                    case (r)
                        0: w = AGE_W'(1);
                        1: w = AGE_W'(WMAX);
                        2: w = AGE_W'(2);
                        3: w = AGE_W'($urandom_range(WMAX + 1, 127));
                        4: w = '0;
                        default: w = AGE_W'($urandom_range(1, WMAX));
                    endcase
                end
            endcase
            program_window(w);
            span = (w == '0) ? AGE_W'(1) : ((w > AGE_W'(WMAX)) ? AGE_W'(WMAX) : w);
            mix = t_value_mix'($urandom_range(0, 3));
            phase_len = $urandom_range(20, 90);
            if (phase == 2) begin
                // one long falling stream: fills the chain, saturates the count
                mix = VALUES_FALLING;
                phase_len = 140;
                stream_left = 140;
            end
            if (phase_len > RANDOM_ITEMS - random_items) begin
                phase_len = RANDOM_ITEMS - random_items;
            end
            tx_burst = ($urandom_range(0, 4) == 0);
            rx_burst = ($urandom_range(0, 4) == 0);
            for (j = 0; j < phase_len; j++) begin
                if (stream_left == 0) begin
                    r = $urandom_range(0, 9);
                    if (r < 6) begin
                        stream_left = $urandom_range(1, int'(span) + 3);
                    end else if (r < 9) begin
                        stream_left = $urandom_range(1, 2 * int'(span) + 10);
                    end else begin
                        stream_left = $urandom_range(100, 160);
                    end
                end
                stream_left--;
                case (mix)
                    VALUES_WIDE: v = SW'($urandom);
                    VALUES_NARROW: v = SW'($urandom_range(0, 6)) - SW'(3);
                    VALUES_EDGE: begin
                        case ($urandom_range(0, 6))
                            0: v = S_MAX;
                            1: v = S_MIN;
                            2: v = '0;
                            3: v = '1;
                            4: v = S_MAX - SW'(1);
                            5: v = S_MIN + SW'(1);
                            default: v = SW'($urandom);
                        endcase
                    end
                    default: begin
                        // mostly falling with repeats, an occasional jump
                        if ($urandom_range(0, 15) == 0) begin
                            ramp_level = SW'($urandom);
                        end else begin
                            ramp_level = ramp_level - SW'($urandom_range(0, 2));
                        end
                        v = ramp_level;
                    end
                endcase
                add_sample(v, stream_left == 0);
                random_items++;
            end
            wait_quiet();
            phase++;
        end

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

endmodule
